[hdl/assert_macros.svh]
// Assertion macros used by the RTL top of the port reservation table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, skipped while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/prt_pkg.sv]
// Types and codes of the port reservation table.
package prt_pkg;

  localparam logic [2:0] OP_RESERVE      = 3'd0;
  localparam logic [2:0] OP_RELEASE_PORT = 3'd1;
  localparam logic [2:0] OP_RELEASE_ID   = 3'd2;
  localparam logic [2:0] OP_RENAME       = 3'd3;
  localparam logic [2:0] OP_QUERY        = 3'd4;
  localparam logic [2:0] OP_LIST         = 3'd5;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_TAKEN    = 3'd1;
  localparam logic [2:0] STAT_FREE     = 3'd2;
  localparam logic [2:0] STAT_NO_ID    = 3'd3;
  localparam logic [2:0] STAT_BAD_PORT = 3'd4;

  localparam int MASK_W = 16;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [5:0]  port_index;
    logic [63:0] job_id;
    logic [63:0] new_job_id;
  } prt_cmd_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              port_busy;
    logic [MASK_W-1:0] port_mask;
    logic [4:0]        reserved_count;
  } prt_res_t;

  typedef enum logic [2:0] {
    PS_IDLE,
    PS_SINGLE,
    PS_SWEEP,
    PS_DRAIN,
    PS_DONE
  } prt_state_t;

endpackage

[hdl/prt_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module prt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/port_reservation_table_top.sv]
// Top level of the port reservation table: command sequencer around the owner-id RAM.
//
//  channel   ports                      handshake
//  command   start, busy, in_cmd        beat taken when start is high and busy is low
//  result    out_strobe, out_res        one beat per command, one cycle, never stalled
//
// Reserve, release port, query and the unused opcodes pass through PS_SINGLE,
// which works out the result and registers the result beat.
// Release id, rename and list walk the owner-id RAM once, one entry a cycle,
// through PS_SWEEP, PS_DRAIN and PS_DONE, and PS_DONE registers the result beat:
// the single RAM read port sets that pace, and its registered read needs PS_DRAIN.
// Reset (rst_n low, synchronous) clears the valid bits and the port count at
// once; the owner ids stay undefined until written, so no clearing pass runs.
// busy stays high from acceptance until the result beat is registered; the
// result side never stalls, so busy is the only hold on the command side.
`include "assert_macros.svh"

module port_reservation_table_top #(
  parameter int NUM_PORTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  prt_pkg::prt_cmd_t  in_cmd,
  output logic               out_strobe,
  output prt_pkg::prt_res_t  out_res
);

  import prt_pkg::*;

  // Address and count widths follow the table depth.
  localparam int AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int TW = $clog2(NUM_PORTS + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_PORTS - 1);

  prt_state_t state_r, state_nxt;
  prt_cmd_t   cmd_r, cmd_nxt;
  prt_res_t   res_r, res_nxt;
  logic       out_strobe_r, out_strobe_nxt;

  // Valid bit for every owner slot; flip-flops so reset clears them at once.
  logic [NUM_PORTS-1:0] valid_r, valid_nxt;
  logic [TW-1:0]        total_r, total_nxt;

  // Sweep pointers: rd_idx issues the read, cmp_idx matches the returned data.
  logic [AW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic              hit_any_r, hit_any_nxt;
  logic [MASK_W-1:0] mask_r, mask_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [63:0]   ram_rdata;

  logic          port_ok;
  logic [AW-1:0] port_sel;
  logic          hit;
  logic [5:0]    cmp_idx6;
  logic          stray_we;

  prt_ram #(
    .WIDTH (64),
    .DEPTH (NUM_PORTS)
  ) u_owner_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign port_ok  = {1'b0, cmd_r.port_index} < 7'(NUM_PORTS);
  assign port_sel = cmd_r.port_index[AW-1:0];
  assign cmp_idx6 = 6'(cmp_idx_r);

  // The RAM data returned this cycle belongs to cmp_idx_r.
  assign hit = cmp_vld_r && valid_r[cmp_idx_r] && (ram_rdata == cmd_r.job_id);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    res_nxt        = res_r;
    out_strobe_nxt = 1'b0;
    valid_nxt      = valid_r;
    total_nxt      = total_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = 1'b0;
    hit_any_nxt    = hit_any_r;
    mask_nxt       = mask_r;
    ram_we         = 1'b0;
    ram_waddr      = cmp_idx_r;
    ram_wdata      = cmd_r.new_job_id;
    ram_raddr      = rd_idx_r;

    // Act on a matching slot during the sweep. A rename writes back to the slot
    // just read while the next is read; at the last slot the write and read addresses meet, and that read is unused.
    if (hit) begin
      hit_any_nxt = 1'b1;
      case (cmd_r.opcode)
        OP_RELEASE_ID: begin
          valid_nxt[cmp_idx_r] = 1'b0;
          total_nxt            = total_r - TW'(1);
        end
        OP_RENAME: begin
          ram_we = 1'b1;
        end
        OP_LIST: begin
          if (cmp_idx6 < 6'(MASK_W)) begin
            mask_nxt[cmp_idx6[3:0]] = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      PS_IDLE: begin
        if (start) begin
          cmd_nxt     = in_cmd;
          hit_any_nxt = 1'b0;
          mask_nxt    = '0;
          rd_idx_nxt  = '0;
          if (in_cmd.opcode inside {OP_RELEASE_ID, OP_RENAME, OP_LIST}) begin
            state_nxt = PS_SWEEP;
          end else begin
            state_nxt = PS_SINGLE;
          end
        end
      end
      PS_SINGLE: begin
        res_nxt.status    = STAT_OK;
        res_nxt.port_busy = 1'b0;
        res_nxt.port_mask = '0;
        case (cmd_r.opcode)
          OP_RESERVE: begin
            if (!port_ok) begin
              res_nxt.status = STAT_BAD_PORT;
            end else if (valid_r[port_sel]) begin
              res_nxt.status = STAT_TAKEN;
            end else begin
              valid_nxt[port_sel] = 1'b1;
              total_nxt           = total_r + TW'(1);
              ram_we              = 1'b1;
              ram_waddr           = port_sel;
              ram_wdata           = cmd_r.job_id;
            end
          end
          OP_RELEASE_PORT: begin
            if (!port_ok) begin
              res_nxt.status = STAT_BAD_PORT;
            end else if (!valid_r[port_sel]) begin
              res_nxt.status = STAT_FREE;
            end else begin
              valid_nxt[port_sel] = 1'b0;
              total_nxt           = total_r - TW'(1);
            end
          end
          OP_QUERY: begin
            if (!port_ok) begin
              res_nxt.status = STAT_BAD_PORT;
            end else begin
              res_nxt.port_busy = valid_r[port_sel];
            end
          end
          default: begin
          end
        endcase
        res_nxt.reserved_count = 5'(total_nxt);
        out_strobe_nxt         = 1'b1;
        state_nxt              = PS_IDLE;
      end
      PS_SWEEP: begin
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = rd_idx_r;
        if (rd_idx_r == LAST_IDX) begin
          state_nxt = PS_DRAIN;
        end else begin
          rd_idx_nxt = rd_idx_r + AW'(1);
        end
      end
      PS_DRAIN: begin
        // Last slot is matched this cycle.
        state_nxt = PS_DONE;
      end
      PS_DONE: begin
        res_nxt.status         = hit_any_r ? STAT_OK : STAT_NO_ID;
        res_nxt.port_busy      = 1'b0;
        res_nxt.port_mask      = (cmd_r.opcode == OP_LIST) ? mask_r : '0;
        res_nxt.reserved_count = 5'(total_r);
        out_strobe_nxt         = 1'b1;
        state_nxt              = PS_IDLE;
      end
      default: begin
        state_nxt = PS_IDLE;
      end
    endcase
  end

  // Control state: cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= PS_IDLE;
      out_strobe_r <= 1'b0;
      valid_r      <= '0;
      total_r      <= '0;
      cmp_vld_r    <= 1'b0;
      rd_idx_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      valid_r      <= valid_nxt;
      total_r      <= total_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      rd_idx_r     <= rd_idx_nxt;
    end
  end

  // Payload: hold the command, the result beat and the sweep match state, no reset needed.
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    res_r     <= res_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hit_any_r <= hit_any_nxt;
    mask_r    <= mask_nxt;
  end

  assign busy       = (state_r != PS_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_res    = res_r;

  // A RAM write outside a single-slot command must come from a rename hit.
  assign stray_we = ram_we && (state_r != PS_SINGLE)
                    && !(cmp_vld_r && (cmd_r.opcode == OP_RENAME));

  `ASSERT_CLK(a_total_bound, total_r <= TW'(NUM_PORTS), "port count exceeds table depth")
  `ASSERT_CLK(a_strobe_single, out_strobe_r |=> !out_strobe_r, "result beat lasted two cycles")
  `ASSERT_CLK(a_idle_no_match, !busy |-> !cmp_vld_r, "slot match pending while idle")
  `ASSERT_CLK(a_rename_write_sweep, !stray_we, "RAM written outside rename sweep")
  `ASSERT_CLK(a_accept_to_busy, (start && !busy) |=> busy, "accepted command did not raise busy")

endmodule

[verif/prt_checker.sv]
// Scoreboard for the port reservation table: shadow ownership table and result comparison.
`timescale 1ns / 1ps

module prt_checker #(
  parameter int NUM_PORTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  prt_pkg::prt_cmd_t in_cmd,
  input  logic              out_strobe,
  input  prt_pkg::prt_res_t out_res,
  output int                fail_count,
  output int                pending_beats
);

  import prt_pkg::*;

  // Shadow of the owner slots; owner_tag is only looked at where slot_taken is set.
  logic [63:0] owner_tag [NUM_PORTS];
  bit          slot_taken [NUM_PORTS];
  int          taken_total;

  prt_res_t    expected_beats [$];
  prt_res_t    want;
  int          failures;

  // Apply one command to the shadow table and return the result beat it must produce.
  function automatic prt_res_t apply_command(prt_cmd_t cmd);
    prt_res_t r;
    bit       port_ok;
    bit       id_known;
    int       p;
    r        = '0;
    r.status = STAT_OK;
    port_ok  = cmd.port_index < NUM_PORTS;
    id_known = 1'b0;
    for (p = 0; p < NUM_PORTS; p++) begin
      if (slot_taken[p] && owner_tag[p] == cmd.job_id) id_known = 1'b1;
    end

    case (cmd.opcode)
      OP_RESERVE: begin
        if (!port_ok) r.status = STAT_BAD_PORT;
        else if (slot_taken[cmd.port_index]) r.status = STAT_TAKEN;
        else begin
          slot_taken[cmd.port_index] = 1'b1;
          owner_tag[cmd.port_index]  = cmd.job_id;
          taken_total++;
        end
      end
      OP_RELEASE_PORT: begin
        if (!port_ok) r.status = STAT_BAD_PORT;
        else if (!slot_taken[cmd.port_index]) r.status = STAT_FREE;
        else begin
          slot_taken[cmd.port_index] = 1'b0;
          taken_total--;
        end
      end
      OP_RELEASE_ID: begin
        if (!id_known) r.status = STAT_NO_ID;
        else begin
          for (p = 0; p < NUM_PORTS; p++) begin
            if (slot_taken[p] && owner_tag[p] == cmd.job_id) begin
              slot_taken[p] = 1'b0;
              taken_total--;
            end
          end
        end
      end
      OP_RENAME: begin
        if (!id_known) r.status = STAT_NO_ID;
        else begin
          for (p = 0; p < NUM_PORTS; p++) begin
            if (slot_taken[p] && owner_tag[p] == cmd.job_id) owner_tag[p] = cmd.new_job_id;
          end
        end
      end
      OP_QUERY: begin
        if (!port_ok) r.status = STAT_BAD_PORT;
        else r.port_busy = slot_taken[cmd.port_index];
      end
      OP_LIST: begin
        if (!id_known) r.status = STAT_NO_ID;
        else begin
          for (p = 0; p < NUM_PORTS && p < MASK_W; p++) begin
            if (slot_taken[p] && owner_tag[p] == cmd.job_id) r.port_mask[p] = 1'b1;
          end
        end
      end
      default: ;
    endcase

    r.reserved_count = taken_total[4:0];
    return r;
  endfunction

  function automatic void compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      failures++;
    end
  endfunction

  // Compare the outgoing beat first, then log the incoming one; both can land on one edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        slot_taken[p] = 1'b0;
        owner_tag[p]  = '0;
      end
      taken_total = 0;
      expected_beats.delete();
    end else begin
      if (out_strobe) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing outstanding: status %0h", out_res.status);
          failures++;
        end else begin
          want = expected_beats.pop_front();
          compare_field("status", 64'(want.status), 64'(out_res.status));
          compare_field("port_busy", 64'(want.port_busy), 64'(out_res.port_busy));
          compare_field("port_mask", 64'(want.port_mask), 64'(out_res.port_mask));
          compare_field("reserved_count", 64'(want.reserved_count),
                        64'(out_res.reserved_count));
        end
      end
      if (start && !busy) expected_beats.push_back(apply_command(in_cmd));
    end
    pending_beats <= expected_beats.size();
    fail_count    <= failures;
  end

endmodule

[verif/tb_port_reservation_table_top.sv]
// Testbench top for the port reservation table: command stimulus, reset, verdict.
`timescale 1ns / 1ps

module tb_port_reservation_table_top;
  import prt_pkg::*;

  localparam int PORTS        = 16;
  // Opcodes with no function: the block must answer them with a plain ok.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS = 1950;
  // Window of random items sent back to back, with no idle cycles at all.
  localparam int CALM_FIRST   = 700;
  localparam int CALM_LAST    = 1000;
  // Longest command: one pass over every owner slot plus overhead.
  localparam int SWEEP_CYCLES = PORTS + 3;
  localparam int POOL_SIZE    = 8;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  prt_cmd_t in_cmd;
  logic     out_strobe;
  prt_res_t out_res;
  int       fail_count;
  int       pending_beats;

  // A small set of owner ids, so reserves, renames and lists keep hitting one another.
  logic [63:0] id_pool [POOL_SIZE];
  bit          calm;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  port_reservation_table_top #(
    .NUM_PORTS (PORTS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_cmd     (in_cmd),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  prt_checker #(
    .NUM_PORTS (PORTS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .out_strobe    (out_strobe),
    .out_res       (out_res),
    .fail_count    (fail_count),
    .pending_beats (pending_beats)
  );

  function automatic prt_cmd_t make_cmd(logic [2:0] op, logic [5:0] port,
                                        logic [63:0] id, logic [63:0] new_id);
    prt_cmd_t c;
    c.opcode     = op;
    c.port_index = port;
    c.job_id     = id;
    c.new_job_id = new_id;
    return c;
  endfunction

  // Present one command beat and hold it until the block takes it. Redraw start every
  // cycle: low with a chance of three in ten, always high inside the calm window.
  task automatic issue(input prt_cmd_t cmd);
    in_cmd <= cmd;
    do begin
      start <= calm || ($urandom_range(99) >= 30);
      @(posedge clk);
    end while (!(start && !busy));
  endtask

  // Mostly ids from the pool; the rest are fresh random owners.
  function automatic logic [63:0] pick_id(int pool_pct);
    if ($urandom_range(99) < pool_pct) return id_pool[$urandom_range(POOL_SIZE - 1)];
    return {$urandom, $urandom};
  endfunction

  // Mostly ports inside the table; one in ten out of range.
  function automatic logic [5:0] pick_port();
    if ($urandom_range(99) < 90) return 6'($urandom_range(PORTS - 1));
    return 6'($urandom_range(63, PORTS));
  endfunction

  // Weight towards reserve and release so the table fills and drains repeatedly.
  function automatic logic [2:0] pick_op();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) return OP_RESERVE;
    if (roll < 50) return OP_RELEASE_PORT;
    if (roll < 60) return OP_RELEASE_ID;
    if (roll < 70) return OP_RENAME;
    if (roll < 84) return OP_QUERY;
    if (roll < 97) return OP_LIST;
    if (roll < 99) return OP_SPARE_LO;
    return OP_SPARE_HI;
  endfunction

  initial begin
    rst_n  <= 1'b0;
    start  <= 1'b0;
    in_cmd <= '0;
    calm    = 1'b0;

    // Keep the all-zero and all-one ids in the pool so every id bit sees both values.
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = {$urandom, $urandom};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Fill every slot first: the owner-id store is undefined after
    // reset, and the sweeping commands read every entry of it.
    for (int p = 0; p < PORTS; p++) begin
      issue(make_cmd(OP_RESERVE, 6'(p), (p < PORTS / 2) ? id_pool[0] : id_pool[1], '0));
    end
    // Reserve a port that is already owned; the table must stay full.
    issue(make_cmd(OP_RESERVE, 6'd3, id_pool[2], '1));
    // Out-of-range ports: the top address and the first one past the table.
    issue(make_cmd(OP_RESERVE, 6'd63, id_pool[2], '0));
    issue(make_cmd(OP_QUERY, 6'(PORTS), '0, '0));
    issue(make_cmd(OP_QUERY, 6'd5, '0, '0));
    issue(make_cmd(OP_LIST, 6'd0, id_pool[1], '0));
    // Rename to the same id is a no-op, then a real move of the upper half.
    issue(make_cmd(OP_RENAME, 6'd0, id_pool[1], id_pool[1]));
    issue(make_cmd(OP_RENAME, 6'd0, id_pool[1], id_pool[3]));
    issue(make_cmd(OP_RELEASE_ID, 6'd0, id_pool[0], '0));
    // Release of a free port, list of an id that holds nothing, and an unused opcode.
    issue(make_cmd(OP_RELEASE_PORT, 6'd2, '0, '0));
    issue(make_cmd(OP_LIST, 6'd0, id_pool[0], '0));
    issue(make_cmd(OP_SPARE_HI, 6'd63, '1, '1));

    // Random part: pooled ids for most commands, noise on ids and ports for the rest.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= CALM_FIRST && n < CALM_LAST);
      issue(make_cmd(pick_op(), pick_port(), pick_id(85), pick_id(70)));
    end

    // Drain: stop sending, wait for every outstanding beat, then allow the longest
    // command time to show any stray beat.
    start <= 1'b0;
    do @(posedge clk); while (pending_beats != 0);
    repeat (2 * SWEEP_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
